FILE: hw/rtl/cbs_pkg.sv
// Shared types, codes and helpers for the coordinate binary search block.
package cbs_pkg;

  // Default table depth
  localparam int unsigned TABLE_DEPTH_DEFAULT = 256;

  // Width of one stored key (three biased 16-bit fields)
  localparam int unsigned KEY_W = 48;

  // Item commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic               cmd;
    logic [7:0]         entry_address;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [7:0] match_index;
  } rsp_t;

  // Comparator result: stored key below target, stored key equal to target
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

  // Flip each sign bit so an unsigned compare of keys orders the triples
  function automatic key_t make_key(input req_t item);
    make_key = {item.coord_x ^ 16'h8000, item.coord_y ^ 16'h8000,
                item.coord_z ^ 16'h8000};
  endfunction

endpackage

FILE: hw/rtl/cbs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/cbs_compare.sv
// Shared 48-bit key comparator used by every search step and the final check.
module cbs_compare (
  input  cbs_pkg::key_t entry,
  input  cbs_pkg::key_t target,
  output cbs_pkg::cmp_t result
);

  // Compare biased keys as unsigned numbers
  always_comb begin
    result.lt = (entry < target);
    result.eq = (entry == target);
  end

endmodule

FILE: hw/rtl/cbs_ctrl.sv
// Sequencer for table writes and the lower-bound search, with the result register.
module cbs_ctrl #(
  parameter int unsigned TABLE_DEPTH = cbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [8:0]                     entries_in_use,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  cbs_pkg::req_t                  req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output cbs_pkg::rsp_t                  rsp,
  output logic                           ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
  output cbs_pkg::key_t                  ram_wdata,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
  output cbs_pkg::key_t                  target,
  input  cbs_pkg::cmp_t                  cmp
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_STEP   = 2'd2;
  localparam logic [1:0] S_CHECK  = 2'd3;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] lo, lo_next;
  logic [CNT_W-1:0] hi, hi_next;
  logic [CNT_W-1:0] mid, mid_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_clamp;
  logic             req_xfer;
  logic             in_range;
  logic             hit;
  logic             rsp_load;

  assign req_ready = (state == S_IDLE);
  assign req_xfer  = req_valid && req_ready;

  // Clamp the entry count to the table depth
  assign count_clamp = (32'(entries_in_use) > 32'(TABLE_DEPTH)) ?
                       CNT_W'(TABLE_DEPTH) : CNT_W'(entries_in_use);

  // Table write port: drop writes past the end of the table
  assign in_range  = (32'(req.entry_address) < 32'(TABLE_DEPTH));
  assign ram_we    = req_xfer && (req.cmd == cbs_pkg::CMD_WRITE) && in_range;
  assign ram_waddr = IDX_W'(req.entry_address);
  assign ram_wdata = cbs_pkg::make_key(req);

  // Midpoint of the open range and the read address
  assign mid       = lo + ((hi - lo) >> 1);
  assign ram_raddr = (state == S_SEARCH && lo != hi) ? mid[IDX_W-1:0] : lo[IDX_W-1:0];

  // Final check on the entry at the lower bound
  assign hit      = (lo < count) && cmp.eq;
  assign rsp_load = (state == S_CHECK) && (!rsp_valid || rsp_ready);

  // Next state and search bounds
  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    unique case (state)
      S_IDLE: begin
        if (req_xfer && req.cmd == cbs_pkg::CMD_LOOKUP) begin
          lo_next    = '0;
          hi_next    = count_clamp;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        state_next = (lo != hi) ? S_STEP : S_CHECK;
      end
      S_STEP: begin
        if (cmp.lt) begin
          lo_next = mid_q + CNT_W'(1);
        end else begin
          hi_next = mid_q;
        end
        state_next = S_SEARCH;
      end
      S_CHECK: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Search datapath and result payload
  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
    if (state == S_SEARCH) begin
      mid_q <= mid;
    end
    if (req_xfer && req.cmd == cbs_pkg::CMD_LOOKUP) begin
      target <= cbs_pkg::make_key(req);
      count  <= count_clamp;
    end
    if (rsp_load) begin
      rsp.found       <= hit;
      rsp.match_index <= hit ? 8'(lo) : 8'd0;
    end
  end

endmodule

FILE: hw/rtl/coordinate_binary_search.sv
// Top level of the coordinate binary search: register port, sequencer, comparator, table.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------
//   req     | in        | req_valid / req_ready  | cbs_pkg::req_t
//   rsp     | out       | rsp_valid / rsp_ready  | cbs_pkg::rsp_t
//   apb     | in        | psel, penable, pwrite  | paddr, pwdata, prdata
//
// A write item goes into the table on its transfer. A lookup is paced by the single
// table read port and the shared comparator: one read and one compare per halving
// step, then one read and one compare for the final check.
// Reset clears control state and entries_in_use; table contents stay undefined.
// A finished result waits in the output register; the block takes new items
// meanwhile, and a second lookup holds in its final step until that result is taken.
module coordinate_binary_search #(
  parameter int unsigned TABLE_DEPTH = cbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cbs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cbs_pkg::rsp_t rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [2:0]  ADDR_ENTRIES_IN_USE = 3'd0;

  logic [8:0]       entries_in_use;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  cbs_pkg::key_t    ram_wdata;
  cbs_pkg::key_t    ram_rdata;
  cbs_pkg::key_t    target;
  cbs_pkg::cmp_t    cmp;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ENTRIES_IN_USE) ? 32'(entries_in_use) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= 9'd0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_ENTRIES_IN_USE) begin
      entries_in_use <= pwdata[8:0];
    end
  end

  cbs_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .entries_in_use(entries_in_use),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .target        (target),
    .cmp           (cmp)
  );

  cbs_compare u_compare (
    .entry (ram_rdata),
    .target(target),
    .result(cmp)
  );

  cbs_ram #(
    .WIDTH(cbs_pkg::KEY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

FILE: hw/rtl/cbs_checker.sv
// Port-level checks for the coordinate binary search, bound to the top level.
module cbs_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input cbs_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input cbs_pkg::rsp_t rsp,
  input logic          pready
);

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // A miss reports index zero
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.match_index == 8'd0)
    else $error("miss with nonzero index");

  // A lookup transfer busies the block in the next cycle
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.cmd == cbs_pkg::CMD_LOOKUP |=> !req_ready)
    else $error("ready during lookup");

  // No result straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid && pready)
    else $error("result valid after reset");

endmodule

bind coordinate_binary_search cbs_checker u_cbs_checker (.*);

FILE: tb/search_checker.sv
// Checker for the coordinate binary search: tracks table and count, predicts and checks lookups.
`timescale 1ns / 100ps
module search_checker #(
  parameter logic [2:0] COUNT_REG_ADDR = 3'd0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  cbs_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  cbs_pkg::rsp_t rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic          pready,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output int            failures,
  output int            outstanding,
  output int            lookups_checked,
  output int            hits_checked
);

  localparam int unsigned DEPTH = cbs_pkg::TABLE_DEPTH_DEFAULT;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } triple_t;

  triple_t       coords [DEPTH];
  logic [8:0]    search_count = '0;
  cbs_pkg::rsp_t pending_answers [$];
  int            mismatches = 0;
  int            lookups = 0;
  int            hits = 0;

  // Lexicographic order, each field signed
  function automatic logic triple_below(input triple_t a, input triple_t b);
    if (a.x != b.x) return $signed(a.x) < $signed(b.x);
    if (a.y != b.y) return $signed(a.y) < $signed(b.y);
    return $signed(a.z) < $signed(b.z);
  endfunction

  // Fixed halving search for the first entry not below the target
  function automatic cbs_pkg::rsp_t lower_bound_lookup(input triple_t target);
    int unsigned   span;
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   mid;
    cbs_pkg::rsp_t answer;
    answer = '0;
    span = (search_count > DEPTH) ? DEPTH : search_count;
    lo = 0;
    hi = span;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (triple_below(coords[mid], target)) lo = mid + 1;
      else hi = mid;
    end
    if (lo < span) begin
      if (coords[lo] == target) begin
        answer.found = 1'b1;
        answer.match_index = lo[7:0];
      end
    end
    return answer;
  endfunction

  always @(posedge clk) begin : watch
    cbs_pkg::rsp_t expected;
    triple_t       item_triple;
    if (rst) begin
      search_count = '0;
    end else begin
      // Track register writes; other addresses hold nothing
      if (psel && penable && pwrite && pready && paddr == COUNT_REG_ADDR) begin
        search_count = pwdata[8:0];
      end

      // Check each result transfer against the oldest answer waiting
      if (rsp_valid && rsp_ready) begin
        if (pending_answers.size() == 0) begin
          mismatches++;
          $error("result with no lookup waiting: found %0d match_index %0d",
                 rsp.found, rsp.match_index);
        end else begin
          expected = pending_answers.pop_front();
          if (rsp.found !== expected.found) begin
            mismatches++;
            $error("found: expected %0d, actual %0d", expected.found, rsp.found);
          end
          if (rsp.match_index !== expected.match_index) begin
            mismatches++;
            $error("match_index: expected %0d, actual %0d",
                   expected.match_index, rsp.match_index);
          end
          lookups++;
          if (expected.found) hits++;
        end
      end

      // Apply writes to the table copy, queue an answer per lookup
      if (req_valid && req_ready) begin
        item_triple = {req.coord_x, req.coord_y, req.coord_z};
        if (req.cmd == cbs_pkg::CMD_WRITE) begin
          if (req.entry_address < DEPTH) coords[req.entry_address] = item_triple;
        end else begin
          pending_answers = {pending_answers, lower_bound_lookup(item_triple)};
        end
      end
    end
    failures        <= mismatches;
    outstanding     <= pending_answers.size();
    lookups_checked <= lookups;
    hits_checked    <= hits;
  end

endmodule

FILE: tb/testbench.sv
// Top of the coordinate binary search bench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;

  localparam logic [2:0]  ENTRIES_IN_USE_ADDR = 3'd0;  // register 0
  localparam logic [2:0]  SPARE_REG_ADDR = 3'd4;       // no register decoded here
  localparam int          DEPTH = cbs_pkg::TABLE_DEPTH_DEFAULT;
  localparam int          DRAIN_CYCLES = 30;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          ROUNDS = 6;
  localparam int          ROUND_ITEMS = 50;
  localparam int          RANDOM_COUNT = -1;
  localparam logic [47:0] MAX_KEY = '1;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  cbs_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  cbs_pkg::rsp_t rsp;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  int unsigned cycle_count = 0;
  int          send_idle_pct = 0;
  int          take_idle_pct = 0;
  int          items_sent = 0;
  int          failures;
  int          outstanding;
  int          lookups_checked;
  int          hits_checked;

  // Biased keys of what each slot holds, used to aim lookups
  logic [47:0] slot_keys [DEPTH];

  // entries_in_use per round: empty, tiny, full, oversized and random sizes
  int count_plan [3*ROUNDS] = '{256, 0, 1, 2, RANDOM_COUNT, 511,
                                255, 257, 3, RANDOM_COUNT, 128, 256,
                                RANDOM_COUNT, 1, 300, 256, 0, 64};

  coordinate_binary_search uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  search_checker #(
    .COUNT_REG_ADDR (ENTRIES_IN_USE_ADDR)
  ) checker_inst (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req             (req),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .rsp             (rsp),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .failures        (failures),
    .outstanding     (outstanding),
    .lookups_checked (lookups_checked),
    .hits_checked    (hits_checked)
  );

  always #6 clk = ~clk;

  // Stall the result side at random
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= take_idle_pct);
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one item after a random gap and hold it until its transfer
  task automatic send_item(input logic cmd, input logic [7:0] addr, input logic [47:0] key);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= {cmd, addr, key[47:32] ^ 16'h8000, key[31:16] ^ 16'h8000, key[15:0] ^ 16'h8000};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (cmd == cbs_pkg::CMD_WRITE) slot_keys[addr] = key;
    items_sent++;
  endtask

  // Hold the sender until every answer is back and the search has gone idle
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle
  task automatic apb_write(input logic [2:0] addr, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Fill every slot with ascending keys: duplicates, z, y, x and random steps, max at the end
  task automatic fill_sorted();
    int          slot;
    logic [47:0] key;
    logic [48:0] step;
    logic [48:0] next_key;
    key = '0;
    for (slot = 0; slot < DEPTH; slot++) begin
      send_item(cbs_pkg::CMD_WRITE, slot[7:0], (slot == DEPTH - 1) ? MAX_KEY : key);
      case ($urandom_range(0, 9))
        0, 1: step = '0;
        2, 3, 4, 5: step = 49'($urandom_range(1, 3));
        6, 7: begin
          step = 49'($urandom_range(1, 3));
          step = step << 16;
        end
        8: begin
          step = 49'($urandom_range(1, 600));
          step = step << 32;
        end
        default: begin
          step = 49'($urandom);
          step = step << 8;
        end
      endcase
      next_key = {1'b0, key} + step;
      key = next_key[48] ? MAX_KEY : next_key[47:0];
    end
  endtask

  // Lookups aimed at stored entries, near misses and random triples, with stray writes
  task automatic run_round(input int setting);
    int          span;
    int          pick;
    int          roll;
    int          n;
    logic [7:0]  addr;
    logic [47:0] target;
    logic [47:0] nudge;
    span = (setting > DEPTH) ? DEPTH : setting;
    for (n = 0; n < ROUND_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      pick = (span > 0) ? $urandom_range(0, span - 1) : 0;
      target = 48'({$urandom, $urandom});
      if (roll < 8) begin
        // overwrite a slot at random; the table may end up unsorted
        addr = 8'($urandom_range(0, 255));
        send_item(cbs_pkg::CMD_WRITE, addr, target);
      end else begin
        if (roll < 60 && span > 0) begin
          target = slot_keys[pick];
        end else if (roll < 85 && span > 0) begin
          case ($urandom_range(0, 2))
            0: nudge = 48'h1;
            1: nudge = 48'h1_0000;
            default: nudge = 48'h1_0000_0000;
          endcase
          target = $urandom_range(0, 1) ? slot_keys[pick] + nudge : slot_keys[pick] - nudge;
        end
        send_item(cbs_pkg::CMD_LOOKUP, 8'h00, target);
      end
    end
  endtask

  initial begin
    int setting;
    int phase;
    int round;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 17;
    take_idle_pct = 80;

    // Empty table after reset: both extremes miss
    send_item(cbs_pkg::CMD_LOOKUP, 8'h00, 48'h0);
    send_item(cbs_pkg::CMD_LOOKUP, 8'h00, MAX_KEY);

    // Small table: minimum, (-1,0,5), (0,0,0) twice, maximum
    send_item(cbs_pkg::CMD_WRITE, 8'd0, 48'h0);
    send_item(cbs_pkg::CMD_WRITE, 8'd1, 48'h7FFF_8000_8005);
    send_item(cbs_pkg::CMD_WRITE, 8'd2, 48'h8000_8000_8000);
    send_item(cbs_pkg::CMD_WRITE, 8'd3, 48'h8000_8000_8000);
    send_item(cbs_pkg::CMD_WRITE, 8'd4, MAX_KEY);
    settle();
    apb_write(ENTRIES_IN_USE_ADDR, 5);

    // Hits on each end, on (-1,0,5) and on the duplicate; misses one step off in z or y, one far off in y
    send_item(cbs_pkg::CMD_LOOKUP, 8'h00, 48'h0);
    send_item(cbs_pkg::CMD_LOOKUP, 8'h00, 48'h7FFF_8000_8005);
    send_item(cbs_pkg::CMD_LOOKUP, 8'h00, 48'h8000_8000_8000);
    send_item(cbs_pkg::CMD_LOOKUP, 8'h00, MAX_KEY);
    send_item(cbs_pkg::CMD_LOOKUP, 8'h00, 48'h7FFF_8000_8004);
    send_item(cbs_pkg::CMD_LOOKUP, 8'h00, 48'h7FFF_8001_8005);
    send_item(cbs_pkg::CMD_LOOKUP, 8'h00, 48'h8000_1234_8000);
    send_item(cbs_pkg::CMD_LOOKUP, 8'h00, 48'hFFFF_FFFF_FFFE);

    // A write to an undecoded address must leave the count alone
    settle();
    apb_write(SPARE_REG_ADDR, 0);
    send_item(cbs_pkg::CMD_LOOKUP, 8'h00, MAX_KEY);

    // Random part under three idle mixes
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 17;
          take_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          take_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      fill_sorted();
      for (round = 0; round < ROUNDS; round++) begin
        setting = count_plan[phase*ROUNDS + round];
        if (setting == RANDOM_COUNT) setting = $urandom_range(1, DEPTH);
        settle();
        apb_write(ENTRIES_IN_USE_ADDR, setting);
        run_round(setting);
      end
    end

    settle();
    $display("Sent %0d items; %0d lookup answers checked, %0d of them hits.",
             items_sent, lookups_checked, hits_checked);
    $display("Table sizes from empty to oversized, sorted and disturbed tables, three idle mixes.");
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
